>>> hw/rtl/lqr_balance_state_feedback_unit_assert.svh
// assertion macros for the lqr balance state feedback unit
// no dependencies; included by the top level
`ifndef LQR_BALANCE_STATE_FEEDBACK_UNIT_ASSERT_SVH
`define LQR_BALANCE_STATE_FEEDBACK_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LQRB_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lqrb: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define LQRB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lqrb: next-cycle check failed");

`endif

>>> hw/rtl/lqrb_pkg.sv
// shared types, constants and the microcode rom of the balance controller
// no dependencies
package lqrb_pkg;

  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VELOCITY   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE_RATE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_WINDOW    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_REFERENCE = 8'd7;

  localparam logic [14:0] DRIVE_LIMIT_RST  = 15'd12288;
  localparam logic [14:0] ANGLE_WINDOW_RST = 15'd5120;

  // degrees to radians, q0.32
  localparam logic [26:0] D2R_Q32 = 27'd74961320;
  // ceil(2^37 / 5), exact floor division by 5 for operands below 2^35
  localparam logic [34:0] RECIP5 = 35'd27487790695;

  typedef struct packed {
    logic signed [15:0] angle_deg;
    logic signed [31:0] cart_count;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [31:0] angle_rate_est;
    logic signed [31:0] cart_velocity_est;
    logic               outside_window;
  } out_t;

  typedef enum logic [3:0] {
    A_DTH, A_DX, A_P, A_THETA, A_FN, A_GP, A_GV, A_GA, A_GR
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SR, B_D2R, B_RECIP, B_X, B_VF, B_THRAD, B_ARF
  } b_sel_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_P, WB_RAWV, WB_RAWR, WB_THRAD, WB_TERM0, WB_TERM16
  } wb_t;

  typedef enum logic [2:0] {
    F_NONE, F_PREP_VEL, F_PREP_RATE, F_FIN_VEL, F_FIN_RATE
  } filt_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [0:0] {
    SEQ_NEXT, SEQ_END
  } seq_op_t;

  typedef struct packed {
    logic    mul_en;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    wb_t     wb;
    filt_t   filt;
    acc_op_t acc;
    logic    u_en;
    seq_op_t seq;
  } ctl_t;

  localparam ctl_t UC_NOP = '{
    mul_en: 1'b0, a_sel: A_DTH, b_sel: B_SR, wb: WB_NONE,
    filt: F_NONE, acc: ACC_NONE, u_en: 1'b0, seq: SEQ_NEXT
  };

  // microprogram: a product issued in one step is consumed in the next
  function automatic ctl_t ucode(input logic [PC_W-1:0] step);
    ctl_t c;
    c = UC_NOP;
    case (step)
      4'd0: begin
        c.mul_en = 1'b1; c.a_sel = A_DTH; c.b_sel = B_SR;
      end
      4'd1: begin
        c.wb = WB_P;
        c.mul_en = 1'b1; c.a_sel = A_DX; c.b_sel = B_SR;
      end
      4'd2: begin
        c.wb = WB_RAWV;
        c.mul_en = 1'b1; c.a_sel = A_P; c.b_sel = B_D2R;
      end
      4'd3: begin
        c.filt = F_PREP_VEL; c.wb = WB_RAWR;
      end
      4'd4: begin
        c.mul_en = 1'b1; c.a_sel = A_FN; c.b_sel = B_RECIP;
      end
      4'd5: begin
        c.filt = F_FIN_VEL;
        c.mul_en = 1'b1; c.a_sel = A_THETA; c.b_sel = B_D2R;
      end
      4'd6: begin
        c.filt = F_PREP_RATE; c.wb = WB_THRAD;
      end
      4'd7: begin
        c.mul_en = 1'b1; c.a_sel = A_FN; c.b_sel = B_RECIP;
      end
      4'd8: begin
        c.filt = F_FIN_RATE;
        c.mul_en = 1'b1; c.a_sel = A_GP; c.b_sel = B_X;
      end
      4'd9: begin
        c.wb = WB_TERM0;
        c.mul_en = 1'b1; c.a_sel = A_GV; c.b_sel = B_VF;
      end
      4'd10: begin
        c.wb = WB_TERM0; c.acc = ACC_LOAD;
        c.mul_en = 1'b1; c.a_sel = A_GA; c.b_sel = B_THRAD;
      end
      4'd11: begin
        c.wb = WB_TERM16; c.acc = ACC_ADD;
        c.mul_en = 1'b1; c.a_sel = A_GR; c.b_sel = B_ARF;
      end
      4'd12: begin
        c.wb = WB_TERM16; c.acc = ACC_ADD;
      end
      4'd13: begin
        c.acc = ACC_ADD;
      end
      4'd14: begin
        c.u_en = 1'b1;
      end
      4'd15: begin
        c.seq = SEQ_END;
      end
      default: begin
        c = UC_NOP;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/lqrb_seq.sv
// microcode sequencer: step counter, busy flag and rom fetch
// depends on lqrb_pkg
module lqrb_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          out_free,
  output logic          busy,
  output lqrb_pkg::ctl_t ctl
);

  logic [lqrb_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      busy_r, busy_nxt;

  assign busy = busy_r;
  assign ctl  = busy_r ? lqrb_pkg::ucode(pc_r) : lqrb_pkg::UC_NOP;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      case (ctl.seq)
        lqrb_pkg::SEQ_NEXT: pc_nxt = pc_r + 1'b1;
        lqrb_pkg::SEQ_END: begin
          // last step waits here until the result register is free
          if (out_free) begin
            busy_nxt = 1'b0;
            pc_nxt   = '0;
          end
        end
        default: pc_nxt = pc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

>>> hw/rtl/lqr_balance_state_feedback_unit.sv
// lqr balance state feedback unit, microcoded around one shared 36x36 multiplier
// a result follows each input beat once the 16-step microprogram feeding the single multiplier
// has run; a new input beat is taken only after the previous one has finished (in_ready is low while busy)
// a final step holds while the previous result beat is still waiting
// reset (rst_n, synchronous): config to its reset values, history and filters
// cleared, no clearing pass; depends on lqrb_pkg, lqrb_seq and the assert header
`include "lqr_balance_state_feedback_unit_assert.svh"

module lqr_balance_state_feedback_unit #(
  parameter int SAMPLE_RATE_HZ = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lqrb_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lqrb_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lqrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam logic signed [35:0] SR_OP    = 36'(SAMPLE_RATE_HZ);
  localparam logic signed [35:0] D2R_OP   = $signed({9'd0, lqrb_pkg::D2R_Q32});
  localparam logic signed [35:0] RECIP_OP = $signed({1'b0, lqrb_pkg::RECIP5});
  localparam logic signed [71:0] TERM_MAX = 72'sh1000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

  // configuration
  logic               enable_r;
  logic signed [31:0] gain_pos_r, gain_vel_r, gain_ang_r, gain_rate_r;
  logic [14:0]        limit_r, window_r;
  logic signed [15:0] ref_r;

  // history and filters
  logic               started_r;
  logic signed [15:0] last_angle_r;
  logic signed [31:0] last_count_r;
  logic signed [31:0] arf_r, vf_r;

  // datapath
  logic signed [15:0] theta_r;
  logic signed [31:0] x_r;
  logic signed [16:0] dth_r;
  logic signed [32:0] dx_r;
  logic signed [33:0] p_r;
  logic signed [49:0] raw_r;
  logic signed [18:0] thrad_r;
  logic               fd_neg_r, fd_sat_r;
  logic [34:0]        fd_n_r;
  logic signed [61:0] term_r;
  logic signed [63:0] acc_r;
  logic signed [56:0] u_r;
  logic signed [71:0] prod_r;

  logic               out_valid_r;
  lqrb_pkg::out_t     out_data_r;

  logic               busy, accept, out_free, seq_done;
  lqrb_pkg::ctl_t     ctl;

  function automatic logic signed [71:0] rnd_shr24(input logic signed [71:0] v);
    logic signed [71:0] bias;
    bias = v[71] ? 72'sd8388607 : 72'sd8388608;
    return (v + bias) >>> 24;
  endfunction

  function automatic logic signed [71:0] rnd_shr16(input logic signed [71:0] v);
    logic signed [71:0] bias;
    bias = v[71] ? 72'sd32767 : 72'sd32768;
    return (v + bias) >>> 16;
  endfunction

  function automatic logic signed [61:0] clamp_term(input logic signed [71:0] v);
    logic signed [61:0] r;
    if (v > TERM_MAX)       r = TERM_MAX[61:0];
    else if (v < -TERM_MAX) r = 62'(-TERM_MAX);
    else                    r = v[61:0];
    return r;
  endfunction

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign seq_done  = busy && (ctl.seq == lqrb_pkg::SEQ_END) && out_free;

  lqrb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  // ---------------- input beat ----------------
  logic signed [16:0] theta_diff;
  logic signed [15:0] theta_in;
  logic signed [16:0] dth_in;
  logic signed [32:0] dx_in;

  always_comb begin
    theta_diff = 17'(in_data.angle_deg) - 17'(ref_r);
    if (theta_diff > 17'sd32767)       theta_in = 16'sh7FFF;
    else if (theta_diff < -17'sd32768) theta_in = 16'sh8000;
    else                               theta_in = theta_diff[15:0];
    // first tick seeds the history, so both raw rates are zero
    dth_in = started_r ? (17'(theta_in) - 17'(last_angle_r)) : '0;
    dx_in  = started_r ? (33'(in_data.cart_count) - 33'(last_count_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      theta_r      <= theta_in;
      x_r          <= in_data.cart_count;
      dth_r        <= dth_in;
      dx_r         <= dx_in;
      last_angle_r <= theta_in;
      last_count_r <= in_data.cart_count;
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [35:0] mul_a, mul_b;

  always_comb begin
    case (ctl.a_sel)
      lqrb_pkg::A_DTH:   mul_a = 36'(dth_r);
      lqrb_pkg::A_DX:    mul_a = 36'(dx_r);
      lqrb_pkg::A_P:     mul_a = 36'(p_r);
      lqrb_pkg::A_THETA: mul_a = 36'(theta_r);
      lqrb_pkg::A_FN:    mul_a = $signed({1'b0, fd_n_r});
      lqrb_pkg::A_GP:    mul_a = 36'(gain_pos_r);
      lqrb_pkg::A_GV:    mul_a = 36'(gain_vel_r);
      lqrb_pkg::A_GA:    mul_a = 36'(gain_ang_r);
      lqrb_pkg::A_GR:    mul_a = 36'(gain_rate_r);
      default:           mul_a = '0;
    endcase
    case (ctl.b_sel)
      lqrb_pkg::B_SR:    mul_b = SR_OP;
      lqrb_pkg::B_D2R:   mul_b = D2R_OP;
      lqrb_pkg::B_RECIP: mul_b = RECIP_OP;
      lqrb_pkg::B_X:     mul_b = 36'(x_r);
      lqrb_pkg::B_VF:    mul_b = 36'(vf_r);
      lqrb_pkg::B_THRAD: mul_b = 36'(thrad_r);
      lqrb_pkg::B_ARF:   mul_b = 36'(arf_r);
      default:           mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod_r <= mul_a * mul_b;
  end

  // ---------------- product write-back ----------------
  logic signed [71:0] r24, r16;

  assign r24 = rnd_shr24(prod_r);
  assign r16 = rnd_shr16(prod_r);

  always_ff @(posedge clk) begin
    case (ctl.wb)
      lqrb_pkg::WB_P:      p_r     <= prod_r[33:0];
      lqrb_pkg::WB_RAWV:   raw_r   <= prod_r[49:0];
      lqrb_pkg::WB_RAWR:   raw_r   <= r24[49:0];
      lqrb_pkg::WB_THRAD:  thrad_r <= r24[18:0];
      lqrb_pkg::WB_TERM0:  term_r  <= clamp_term(prod_r);
      lqrb_pkg::WB_TERM16: term_r  <= clamp_term(r16);
      default: ;
    endcase
  end

  // ---------------- first-order filters, f += round((raw - f) / 5) ----------------
  logic               is_vel;
  logic signed [31:0] f_cur, f_new;
  logic signed [50:0] fd_d;
  logic [50:0]        fd_n;
  logic [32:0]        q;
  logic signed [34:0] f_ext, q_ext, f_sum;

  always_comb begin
    is_vel = (ctl.filt == lqrb_pkg::F_PREP_VEL) || (ctl.filt == lqrb_pkg::F_FIN_VEL);
    f_cur  = is_vel ? vf_r : arf_r;
    fd_d   = 51'(raw_r) - 51'(f_cur);
    // magnitude plus the rounding half of a fifth
    fd_n   = fd_d[50] ? (~fd_d + 51'd3) : (fd_d + 51'd2);
    q      = prod_r[69:37];
    f_ext  = 35'(f_cur);
    q_ext  = $signed({2'b00, q});
    f_sum  = fd_neg_r ? (f_ext - q_ext) : (f_ext + q_ext);
    // a magnitude at or above 2^35 always overflows the 32-bit result
    if (fd_sat_r)                  f_new = fd_neg_r ? S32_MIN : S32_MAX;
    else if (f_sum > 35'(S32_MAX)) f_new = S32_MAX;
    else if (f_sum < 35'(S32_MIN)) f_new = S32_MIN;
    else                           f_new = f_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if ((ctl.filt == lqrb_pkg::F_PREP_VEL) || (ctl.filt == lqrb_pkg::F_PREP_RATE)) begin
      fd_neg_r <= fd_d[50];
      fd_sat_r <= |fd_n[50:35];
      fd_n_r   <= fd_n[34:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r  <= '0;
      arf_r <= '0;
    end else begin
      if (ctl.filt == lqrb_pkg::F_FIN_VEL)  vf_r  <= f_new;
      if (ctl.filt == lqrb_pkg::F_FIN_RATE) arf_r <= f_new;
    end
  end

  // ---------------- feedback sum and rounding ----------------
  logic signed [64:0] u_wide;

  assign u_wide = ((acc_r > 64'sd0) ? 65'sd127 : 65'sd128) - 65'(acc_r);

  always_ff @(posedge clk) begin
    case (ctl.acc)
      lqrb_pkg::ACC_LOAD: acc_r <= 64'(term_r);
      lqrb_pkg::ACC_ADD:  acc_r <= acc_r + 64'(term_r);
      default: ;
    endcase
    if (ctl.u_en) u_r <= u_wide[64:8];
  end

  // ---------------- result beat ----------------
  logic signed [56:0] lim;
  logic signed [16:0] theta17, win17;
  logic               outside;
  logic signed [56:0] drive_c;
  lqrb_pkg::out_t     res;

  always_comb begin
    lim     = $signed({42'd0, limit_r});
    theta17 = 17'(theta_r);
    win17   = $signed({2'b00, window_r});
    outside = !enable_r || (theta17 > win17) || (theta17 < -win17);
    if (u_r > lim)       drive_c = lim;
    else if (u_r < -lim) drive_c = -lim;
    else                 drive_c = u_r;
    res.drive             = outside ? 16'sd0 : drive_c[15:0];
    res.angle_rate_est    = arf_r;
    res.cart_velocity_est = vf_r;
    res.outside_window    = outside;
  end

  always_ff @(posedge clk) begin
    if (seq_done) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (seq_done)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (accept)         started_r   <= 1'b1;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      gain_pos_r  <= '0;
      gain_vel_r  <= '0;
      gain_ang_r  <= '0;
      gain_rate_r <= '0;
      limit_r     <= lqrb_pkg::DRIVE_LIMIT_RST;
      window_r    <= lqrb_pkg::ANGLE_WINDOW_RST;
      ref_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lqrb_pkg::REG_ENABLE:          enable_r    <= cfg_data[0];
        lqrb_pkg::REG_GAIN_POSITION:   gain_pos_r  <= cfg_data;
        lqrb_pkg::REG_GAIN_VELOCITY:   gain_vel_r  <= cfg_data;
        lqrb_pkg::REG_GAIN_ANGLE:      gain_ang_r  <= cfg_data;
        lqrb_pkg::REG_GAIN_ANGLE_RATE: gain_rate_r <= cfg_data;
        lqrb_pkg::REG_DRIVE_LIMIT:     limit_r     <= cfg_data[14:0];
        lqrb_pkg::REG_ANGLE_WINDOW:    window_r    <= cfg_data[14:0];
        lqrb_pkg::REG_ANGLE_REFERENCE: ref_r       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `LQRB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `LQRB_ASSERT_SAME(a_outside_zero, clk, rst_n, out_valid && out_data.outside_window, out_data.drive == 16'sd0)
  `LQRB_ASSERT_NEXT(a_result_loaded, clk, rst_n, seq_done, out_valid && in_ready)

endmodule

>>> tb/lqr_balance_state_feedback_unit_tb.sv
// self-checking testbench for lqr_balance_state_feedback_unit: a bit-exact fixed-point
// model of the balance controller predicts every result beat under random stalls
// depends on lqrb_pkg and the unit under test
`timescale 1ns / 1ps

module lqr_balance_state_feedback_unit_tb;
  import lqrb_pkg::*;

  localparam longint RATE_HZ     = 1000;
  localparam longint DEG2RAD_Q32 = 64'sd74961320;
  localparam longint TERM_LIM    = 64'sh1000_0000_0000_0000;
  localparam longint S32_MIN     = -64'sd2147483648;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     RX_HOLD     = 300;
  localparam int     ITEM_TARGET = 700;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // controller settings as last written
  logic   ctl_enable;
  longint k_pos, k_vel, k_ang, k_rate;
  longint lim, win, angle_ref;
  // estimator history
  bit     seeded;
  longint prev_angle, prev_count, rate_filt, vel_filt;

  out_t   pending_cmds[$];
  int     err_count;
  int     items_sent;
  int     cycle_count;
  bit     tx_steady, rx_steady, hold_req;
  int     rx_stall;
  longint traj_angle, traj_count;

  lqr_balance_state_feedback_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // shift right with rounding to nearest, ties away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // first-order smoothing, one fifth of the step, rounded, saturated to 32 bits
  function automatic longint smooth(input longint f, input longint raw);
    longint d, m, q;
    d = raw - f;
    m = (d < 0) ? -d : d;
    q = (m + 2) / 5;
    return sat(f + ((d < 0) ? -q : q), S32_MIN, S32_MAX);
  endfunction

  function automatic void reset_controller();
    ctl_enable = 1'b0;
    k_pos = 0; k_vel = 0; k_ang = 0; k_rate = 0;
    lim = 12288; win = 5120; angle_ref = 0;
    seeded = 1'b0;
    prev_angle = 0; prev_count = 0; rate_filt = 0; vel_filt = 0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] val);
    case (idx)
      REG_ENABLE:          ctl_enable = val[0];
      REG_GAIN_POSITION:   k_pos = longint'($signed(val));
      REG_GAIN_VELOCITY:   k_vel = longint'($signed(val));
      REG_GAIN_ANGLE:      k_ang = longint'($signed(val));
      REG_GAIN_ANGLE_RATE: k_rate = longint'($signed(val));
      REG_DRIVE_LIMIT:     lim = longint'(val[14:0]);
      REG_ANGLE_WINDOW:    win = longint'(val[14:0]);
      REG_ANGLE_REFERENCE: angle_ref = longint'($signed(val[15:0]));
      default: ;
    endcase
  endfunction

  function automatic out_t next_command(input in_t d);
    out_t   r;
    longint th, x, raw_rate, raw_vel, th_rad, tp, tv, ta, tr, u;
    bit     outside;
    th = sat(longint'(d.angle_deg) - angle_ref, -32768, 32767);
    x  = longint'(d.cart_count);
    if (!seeded) begin
      prev_angle = th;
      prev_count = x;
      seeded = 1'b1;
    end
    raw_rate = round_shift((th - prev_angle) * RATE_HZ * DEG2RAD_Q32, 24);
    raw_vel  = (x - prev_count) * RATE_HZ;
    rate_filt = smooth(rate_filt, raw_rate);
    vel_filt  = smooth(vel_filt, raw_vel);
    prev_angle = th;
    prev_count = x;
    th_rad = round_shift(th * DEG2RAD_Q32, 24);
    tp = sat(k_pos * x, -TERM_LIM, TERM_LIM);
    tv = sat(k_vel * vel_filt, -TERM_LIM, TERM_LIM);
    ta = sat(round_shift(k_ang * th_rad, 16), -TERM_LIM, TERM_LIM);
    tr = sat(round_shift(k_rate * rate_filt, 16), -TERM_LIM, TERM_LIM);
    u = round_shift(-(tp + tv + ta + tr), 8);
    outside = !ctl_enable || (th > win) || (th < -win);
    u = outside ? 0 : sat(u, -lim, lim);
    r.drive             = u[15:0];
    r.angle_rate_est    = rate_filt[31:0];
    r.cart_velocity_est = vel_filt[31:0];
    r.outside_window    = outside;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk_item(input longint a, input longint c);
    in_t d;
    d.angle_deg  = a[15:0];
    d.cart_count = c[31:0];
    return d;
  endfunction

  // a slowly moving pendulum and cart around the upright, with some raw noise
  function automatic in_t gen_item();
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 15) == 0)
        traj_angle = 0;
      else
        traj_angle += longint'($urandom_range(0, 128)) - 64;
      if (traj_angle > win + 256 || traj_angle < -win - 256)
        traj_angle = 0;
      traj_count += longint'($urandom_range(0, 200)) - 100;
      return mk_item(sat(angle_ref + traj_angle, -32768, 32767), traj_count);
    end
    return mk_item(longint'($urandom()), longint'($urandom()));
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3, 4:    return $urandom();
      default: return 32'($urandom_range(0, 8192)) - 32'd4096;
    endcase
  endfunction

  function automatic logic [14:0] pick_mag();
    case ($urandom_range(0, 5))
      0:       return 15'd0;
      1:       return 15'h7fff;
      2:       return 15'($urandom_range(1, 64));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] pick_reference();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0;
      default: return 16'($urandom_range(0, 4096)) - 16'd2048;
    endcase
  endfunction

  task automatic send_item(input in_t d);
    int g;
    g = tx_steady ? 0 : ($urandom_range(0, 1) ? 0 : gap_len());
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(next_command(d));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic write_setting(input logic en, input logic [31:0] gp, input logic [31:0] gv,
                               input logic [31:0] ga, input logic [31:0] gr,
                               input logic [14:0] dl, input logic [14:0] aw,
                               input logic [15:0] ar);
    logic [31:0] v;
    v = $urandom(); v[0] = en;     cfg_write(REG_ENABLE, v);
    cfg_write(REG_GAIN_POSITION, gp);
    cfg_write(REG_GAIN_VELOCITY, gv);
    cfg_write(REG_GAIN_ANGLE, ga);
    cfg_write(REG_GAIN_ANGLE_RATE, gr);
    v = $urandom(); v[14:0] = dl;  cfg_write(REG_DRIVE_LIMIT, v);
    v = $urandom(); v[14:0] = aw;  cfg_write(REG_ANGLE_WINDOW, v);
    v = $urandom(); v[15:0] = ar;  cfg_write(REG_ANGLE_REFERENCE, v);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_item(gen_item());
  endtask

  // reset settings: disabled, so every beat reports outside with zero drive;
  // the first beat seeds the history
  task automatic test_reset_state();
    send_item(mk_item(1000, 12345));
    send_item(mk_item(32767, S32_MAX));
    send_item(mk_item(-32768, S32_MIN));
    send_item(mk_item(0, 0));
    drain();
  endtask

  task automatic test_directed();
    write_setting(1'b1, 32'h0000_0100, 32'h0000_0010, 32'h0040_0000, 32'h0001_0000,
                  15'd12288, 15'd5120, 16'h0);
    // window edges
    send_item(mk_item(0, 0));
    send_item(mk_item(5120, 10));
    send_item(mk_item(5121, 10));
    send_item(mk_item(-5120, -10));
    send_item(mk_item(-5121, -10));
    // full-scale swings drive both filters and the velocity saturation
    send_item(mk_item(0, S32_MAX));
    send_item(mk_item(0, S32_MIN));
    send_item(mk_item(0, S32_MAX));
    send_item(mk_item(0, S32_MIN));
    send_item(mk_item(32767, 0));
    send_item(mk_item(-32768, 0));
    send_item(mk_item(100, 50000));
    drain();
    // extreme gains clamp the product terms of the full-scale beats, drive hits its limit
    write_setting(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  15'd12288, 15'h7fff, 16'h0);
    send_item(mk_item(200, S32_MAX));
    send_item(mk_item(-200, S32_MIN));
    send_item(mk_item(0, 1));
    send_item(mk_item(0, -1));
    drain();
    // subtracting the reference saturates the angle at both ends
    write_setting(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'd256, 15'h7fff, 16'h7fff);
    send_item(mk_item(-32768, 0));
    send_item(mk_item(32767, 0));
    drain();
    write_setting(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'd256, 15'h7fff, 16'h8000);
    send_item(mk_item(32767, 0));
    send_item(mk_item(-32768, 0));
    drain();
    // writes past the last register leave everything as it was
    cfg_write(8'd8, $urandom());
    cfg_write(8'hff, $urandom());
    send_item(mk_item(1234, 77));
    drain();
  endtask

  task automatic test_config_extremes();
    // zero limit, zero window, disabled, then the widest of everything
    write_setting(1'b1, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  15'd0, 15'd3000, 16'h0);
    send_random(15);
    drain();
    write_setting(1'b1, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  15'd2000, 15'd0, 16'h0);
    send_random(15);
    drain();
    write_setting(1'b0, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  15'h7fff, 15'h7fff, 16'h0);
    send_random(15);
    drain();
    write_setting(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                  15'h7fff, 15'h7fff, 16'h8000);
    send_random(15);
    drain();
  endtask

  // receiver holds off while the sender keeps offering beats back to back
  task automatic test_output_stall();
    write_setting(1'b1, pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  15'd12288, 15'd5120, 16'h0);
    @(posedge clk);
    hold_req = 1'b1;
    tx_steady = 1'b1;
    send_random(30);
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) begin
      write_setting($urandom_range(0, 7) != 0, pick_gain(), pick_gain(), pick_gain(),
                    pick_gain(), pick_mag(), pick_mag(), pick_reference());
      if ($urandom_range(0, 3) == 0)
        cfg_write(8'($urandom_range(8, 255)), $urandom());
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      send_random($urandom_range(20, 60));
      drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // result side: random back-pressure, plus a long hold on request
  initial begin
    out_ready = 1'b0;
    rx_stall  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = RX_HOLD;
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        rx_stall = gap_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("result beat with nothing expected: drive %0d", out_data.drive);
        err_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_data.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, out_data.drive);
          err_count++;
        end
        if (out_data.angle_rate_est !== want.angle_rate_est) begin
          $error("angle_rate_est: expected %0d, got %0d",
                 want.angle_rate_est, out_data.angle_rate_est);
          err_count++;
        end
        if (out_data.cart_velocity_est !== want.cart_velocity_est) begin
          $error("cart_velocity_est: expected %0d, got %0d",
                 want.cart_velocity_est, out_data.cart_velocity_est);
          err_count++;
        end
        if (out_data.outside_window !== want.outside_window) begin
          $error("outside_window: expected %0d, got %0d",
                 want.outside_window, out_data.outside_window);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    hold_req   = 1'b0;
    err_count  = 0;
    items_sent = 0;
    cycle_count = 0;
    traj_angle = 0;
    traj_count = 0;
    reset_controller();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_config_extremes();
    test_output_stall();
    test_random_traffic();

    drain();
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
